[rtl/assert_macros.svh]
// assertion macros shared by the rtl modules
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: invariant violated");

// implication checked in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst_n, trig, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error("%m: next-cycle check violated");

`endif

[rtl/lprd_pkg.sv]
// shared types and constants for the length-prefixed record decoder
// no dependencies; imported by length_prefixed_record_decoder
`default_nettype none

package lprd_pkg;

    // default record limit and string capacities
    localparam int MAX_RECORDS_DEF = 16;
    localparam int ID_CAPACITY     = 16;
    localparam int NAME_CAPACITY   = 32;
    localparam int LABEL_CAPACITY  = 32;

    // number of characters kept in each field
    localparam logic [7:0] ID_LIMIT    = 8'(ID_CAPACITY - 1);
    localparam logic [7:0] NAME_LIMIT  = 8'(NAME_CAPACITY - 1);
    localparam logic [7:0] LABEL_LIMIT = 8'(LABEL_CAPACITY - 1);

    // field codes
    localparam logic [1:0] FLD_ID    = 2'd0;
    localparam logic [1:0] FLD_NAME  = 2'd1;
    localparam logic [1:0] FLD_LABEL = 2'd2;

    // parser phase
    typedef enum logic [2:0] {
        PH_POSITION = 3'd0,
        PH_COUNT    = 3'd1,
        PH_LENGTH   = 3'd2,
        PH_CHARS    = 3'd3,
        PH_DRAIN    = 3'd4
    } phase_t;

    // classification of one word
    typedef enum logic [2:0] {
        KIND_SKIP  = 3'd0,
        KIND_POS   = 3'd1,
        KIND_COUNT = 3'd2,
        KIND_LEN   = 3'd3,
        KIND_CHAR  = 3'd4
    } byte_kind_t;

    // message end status
    typedef enum logic [1:0] {
        ST_OPEN   = 2'd0,
        ST_ACCEPT = 2'd1,
        ST_REJECT = 2'd2
    } end_status_t;

    // one result word
    typedef struct packed {
        byte_kind_t  kind;
        logic [3:0]  rec;
        logic [1:0]  fld;
        logic [7:0]  pos;
        logic [7:0]  val;
        end_status_t status;
        logic [4:0]  total;
    } result_t;

endpackage

`default_nettype wire

[rtl/length_prefixed_record_decoder.sv]
// Length-prefixed record decoder: classifies each message word in a single pass
// Depends on lprd_pkg and assert_macros.svh
//
// Usage:
//   Input channel (in_valid/in_ready) carries one message word per transfer:
//   data_byte and last_byte, the latter marking the final word of a message.
//   Output channel (out_valid/out_ready) returns exactly one result word per
//   input word: its kind, record, field, character position and value, plus
//   end_status on the final word, and record_total when that word is accepted.
//   Results are registered in the output or skid register (the latter on a stall).
//   Throughput: one word per cycle while the skid is empty; the parser state
//   update is a single compare-and-increment step from input to result register.
//   Stall: a result register plus a one-word skid register sit on the output,
//   so a word is still taken in the cycle the receiver first stalls; in_ready
//   drops only while the skid register is full.
//   Reset: clears the parser to expect a position header and empties both
//   output registers. After the final word of a message the parser returns
//   to the same state, so the next word opens a new message.
//   On reject, characters already delivered for that message are discarded
//   by the receiver.
`default_nettype none
`include "assert_macros.svh"

module length_prefixed_record_decoder
    import lprd_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      byte_kind,
    output logic [3:0]      record_index,
    output logic [1:0]      field_select,
    output logic [7:0]      char_position,
    output logic [7:0]      item_value,
    output logic [1:0]      end_status,
    output logic [4:0]      record_total
);

    localparam int         RW      = $clog2(MAX_RECORDS + 1);
    localparam logic [7:0] MAX_CNT = 8'(MAX_RECORDS);

    // parser state
    phase_t          phase_reg, phase_next;
    logic [RW-1:0]   record_counter_reg, record_counter_next;
    logic [1:0]      field_counter_reg, field_counter_next;
    logic [7:0]      bytes_remaining_reg, bytes_remaining_next;
    logic [7:0]      char_counter_reg, char_counter_next;
    logic [RW-1:0]   declared_count_reg, declared_count_next;
    logic            failed_flag_reg, failed_flag_next;

    // output and skid registers
    result_t         out_reg, out_next;
    logic            out_valid_reg, out_valid_next;
    result_t         skid_reg, skid_next;
    logic            skid_valid_reg, skid_valid_next;

    logic            in_acc;
    logic            out_take;
    result_t         res;

    // helpers for the field step
    logic [7:0]      keep_lim;
    logic [1:0]      fld_adv;
    logic [RW-1:0]   rec_adv;
    phase_t          phase_adv;
    phase_t          phase_step;
    logic [7:0]      rec_wide;
    logic [7:0]      decl_wide;
    logic [7:0]      rem_dec;

    assign in_ready = !skid_valid_reg;
    assign in_acc   = in_valid && in_ready;
    assign out_take = out_valid_reg && out_ready;

    // kept-character limit of the current field
    always_comb
    begin
        unique case (field_counter_reg)
            FLD_ID:   keep_lim = ID_LIMIT;
            FLD_NAME: keep_lim = NAME_LIMIT;
            default:  keep_lim = LABEL_LIMIT;
        endcase
    end

    // advance to the next field or record
    always_comb
    begin
        if (field_counter_reg == FLD_LABEL)
        begin
            fld_adv = FLD_ID;
            rec_adv = record_counter_reg + RW'(1);
        end
        else
        begin
            fld_adv = field_counter_reg + 2'd1;
            rec_adv = record_counter_reg;
        end
        phase_adv = (rec_adv >= declared_count_reg) ? PH_DRAIN : PH_LENGTH;
    end

    assign rem_dec = (bytes_remaining_reg != 8'd0) ? bytes_remaining_reg - 8'd1
                                                    : 8'd0;

    // next parser state
    always_comb
    begin
        phase_step           = phase_reg;
        record_counter_next  = record_counter_reg;
        field_counter_next   = field_counter_reg;
        bytes_remaining_next = bytes_remaining_reg;
        char_counter_next    = char_counter_reg;
        declared_count_next  = declared_count_reg;
        failed_flag_next     = failed_flag_reg;
        unique case (phase_reg)
            PH_POSITION:
            begin
                phase_step = PH_COUNT;
            end
            PH_COUNT:
            begin
                declared_count_next = RW'(data_byte);
                record_counter_next = '0;
                field_counter_next  = FLD_ID;
                if (data_byte > MAX_CNT)
                begin
                    failed_flag_next = 1'b1;
                    phase_step       = PH_DRAIN;
                end
                else if (data_byte == 8'd0)
                begin
                    phase_step = PH_DRAIN;
                end
                else
                begin
                    phase_step = PH_LENGTH;
                end
            end
            PH_LENGTH:
            begin
                bytes_remaining_next = data_byte;
                char_counter_next    = 8'd0;
                if (data_byte == 8'd0)
                begin
                    field_counter_next  = fld_adv;
                    record_counter_next = rec_adv;
                    phase_step          = phase_adv;
                end
                else
                begin
                    phase_step = PH_CHARS;
                end
            end
            PH_CHARS:
            begin
                if (char_counter_reg != 8'hff)
                begin
                    char_counter_next = char_counter_reg + 8'd1;
                end
                bytes_remaining_next = rem_dec;
                if (rem_dec == 8'd0)
                begin
                    field_counter_next  = fld_adv;
                    record_counter_next = rec_adv;
                    phase_step          = phase_adv;
                end
            end
            PH_DRAIN:
            begin
                phase_step = PH_DRAIN;
            end
            default:
            begin
                phase_step = phase_reg;
            end
        endcase
        phase_next = phase_step;
        // end of message returns to the reset state
        if (last_byte)
        begin
            phase_next           = PH_POSITION;
            record_counter_next  = '0;
            field_counter_next   = FLD_ID;
            bytes_remaining_next = 8'd0;
            char_counter_next    = 8'd0;
            declared_count_next  = '0;
            failed_flag_next     = 1'b0;
        end
    end

    assign rec_wide  = 8'(record_counter_reg);
    assign decl_wide = 8'(declared_count_reg);

    // failure as left by this word, before the end-of-message clear
    function automatic logic failed_flag_next_pre();
        logic f;
        f = failed_flag_reg;
        if (phase_reg == PH_COUNT && data_byte > MAX_CNT)
        begin
            f = 1'b1;
        end
        return f;
    endfunction

    // declared count as left by this word, low bits only
    function automatic logic [4:0] count_total();
        logic [7:0] c;
        c = decl_wide;
        if (phase_reg == PH_COUNT)
        begin
            c = data_byte;
        end
        return c[4:0];
    endfunction

    // result word for the current input word
    always_comb
    begin
        res        = '0;
        res.kind   = KIND_SKIP;
        res.status = ST_OPEN;
        unique case (phase_reg)
            PH_POSITION:
            begin
                res.kind = KIND_POS;
                res.val  = data_byte;
            end
            PH_COUNT:
            begin
                res.kind = KIND_COUNT;
                res.val  = data_byte;
            end
            PH_LENGTH:
            begin
                res.kind = KIND_LEN;
                res.rec  = rec_wide[3:0];
                res.fld  = field_counter_reg;
                res.val  = (data_byte < keep_lim) ? data_byte : keep_lim;
            end
            PH_CHARS:
            begin
                if (char_counter_reg < keep_lim)
                begin
                    res.kind = KIND_CHAR;
                    res.rec  = rec_wide[3:0];
                    res.fld  = field_counter_reg;
                    res.pos  = char_counter_reg;
                    res.val  = data_byte;
                end
            end
            PH_DRAIN:
            begin
                res.kind = KIND_SKIP;
            end
            default:
            begin
                res.kind = KIND_SKIP;
            end
        endcase
        if (last_byte)
        begin
            if (!failed_flag_next_pre() && phase_step == PH_DRAIN)
            begin
                res.status = ST_ACCEPT;
                res.total  = count_total();
            end
            else
            begin
                res.status = ST_REJECT;
            end
        end
    end

    // output register and skid word control
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_acc)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_POSITION;
            record_counter_reg  <= '0;
            field_counter_reg   <= FLD_ID;
            bytes_remaining_reg <= 8'd0;
            char_counter_reg    <= 8'd0;
            declared_count_reg  <= '0;
            failed_flag_reg     <= 1'b0;
            out_valid_reg       <= 1'b0;
            skid_valid_reg      <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                phase_reg           <= phase_next;
                record_counter_reg  <= record_counter_next;
                field_counter_reg   <= field_counter_next;
                bytes_remaining_reg <= bytes_remaining_next;
                char_counter_reg    <= char_counter_next;
                declared_count_reg  <= declared_count_next;
                failed_flag_reg     <= failed_flag_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid     = out_valid_reg;
    assign byte_kind     = out_reg.kind;
    assign record_index  = out_reg.rec;
    assign field_select  = out_reg.fld;
    assign char_position = out_reg.pos;
    assign item_value    = out_reg.val;
    assign end_status    = out_reg.status;
    assign record_total  = out_reg.total;

    // skid word only ever sits behind a full output register
    `ASSERT_ALWAYS(a_skid_behind_out, clk, rst_n, !skid_valid_reg || out_valid_reg)
    // a field being read always has bytes outstanding
    `ASSERT_ALWAYS(a_chars_pending, clk, rst_n,
        phase_reg != PH_CHARS || bytes_remaining_reg != 8'd0)
    // record counter never passes the declared count
    `ASSERT_ALWAYS(a_rec_bounded, clk, rst_n, record_counter_reg <= declared_count_reg)
    // final word of a message rewinds the parser
    `ASSERT_NEXT(a_last_rewinds, clk, rst_n, in_acc && last_byte,
        phase_reg == PH_POSITION && !failed_flag_reg)

endmodule

`default_nettype wire
